[sv/assert_macros.svh]
// Assertion helpers used by the port-level checker.
// Each macro expects a signal named clk, and PPUR_ASSERT also rst_n, in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PPUR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PPUR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ppur_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool package
// Shared types, constants and helpers of the particle pool block.
// ----------------------------------------------------------------------------
package ppur_pkg;

  localparam int TWO_PI_Q  = 411775;
  localparam int SPIN_RATE = 20;
  localparam int HALF_Q16  = 32768;
  localparam int FRAC_ONE  = 65536;
  localparam int DIV_STEPS = 16;
  localparam int MOD_STEPS = 6;
  localparam int ANG_W     = 19;
  localparam int SUM_W     = 25;

  typedef enum logic [1:0] {
    OP_EMIT    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RENDER  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_VEL_SPREAD_X = 3'd0,
    REG_VEL_SPREAD_Y = 3'd1,
    REG_START_COLOR  = 3'd2,
    REG_FINAL_COLOR  = 3'd3,
    REG_LIFE_SPAN    = 3'd4,
    REG_START_SIZE   = 3'd5,
    REG_SIZE_SPREAD  = 3'd6,
    REG_END_SIZE     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EMIT_MUL,
    ST_EMIT_WR,
    ST_DONE,
    ST_ADV_SCAN,
    ST_ADV_CHK,
    ST_ADV_MOD,
    ST_ADV_WR,
    ST_ADV_NEXT,
    ST_REN_SCAN,
    ST_REN_DIV0,
    ST_REN_DIV,
    ST_REN_MUL,
    ST_REN_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] base_vel_x;
    logic signed [31:0] base_vel_y;
    logic [15:0]        rand_angle;
    logic [15:0]        rand_jitter_x;
    logic [15:0]        rand_jitter_y;
    logic [15:0]        rand_size;
    logic [19:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic               draw_valid;
    logic signed [31:0] draw_x;
    logic signed [31:0] draw_y;
    logic [18:0]        draw_angle;
    logic signed [31:0] draw_size;
    logic [31:0]        draw_color;
    logic [6:0]         alive_total;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [18:0]        angle;
    logic signed [31:0] life_left;
    logic signed [31:0] life_total;
    logic [31:0]        color_begin;
    logic [31:0]        color_end;
    logic signed [31:0] size_begin;
    logic signed [31:0] size_end;
  } slot_t;

  typedef struct packed {
    logic take;
    logic ptr_step;
    logic emit_mul;
    logic emit_wr;
    logic ram_rd;
    logic idx_inc;
    logic retire;
    logic adv_mul;
    logic mod_step;
    logic adv_wr;
    logic div_init;
    logic div_step;
    logic rnd_mul;
    logic out_empty;
    logic out_draw;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic emit_free;
    logic any_act;
    logic slot_act;
    logic idx_end;
    logic more_after;
    logic life_dead;
    logic frac_direct;
    logic out_free;
  } ctl_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v[39:31] == 9'h000 || v[39:31] == 9'h1FF) begin
      res = v[31:0];
    end else if (v[39]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

[sv/ppur_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface ppur_in_if;
  logic               valid;
  logic               ready;
  ppur_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppur_out_if;
  logic                valid;
  logic                ready;
  ppur_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppur_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ppur_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ppur_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool controller
// Sequences emit, advance and render over the slot datapath.
// ----------------------------------------------------------------------------
module ppur_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppur_pkg::ctl_sts_t  sts,
  output ppur_pkg::ctl_cmd_t  cmd
);

  ppur_pkg::state_t state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             mod_last, div_last;

  assign mod_last = (step_r == 4'(ppur_pkg::MOD_STEPS - 1));
  assign div_last = (step_r == 4'(ppur_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppur_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppur_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ppur_pkg::ST_DISPATCH;
      end
      ppur_pkg::ST_DISPATCH: begin
        unique case (sts.op)
          ppur_pkg::OP_EMIT:
            state_nxt = sts.emit_free ? ppur_pkg::ST_EMIT_MUL : ppur_pkg::ST_DONE;
          ppur_pkg::OP_ADVANCE: state_nxt = ppur_pkg::ST_ADV_SCAN;
          ppur_pkg::OP_RENDER:
            state_nxt = sts.any_act ? ppur_pkg::ST_REN_SCAN : ppur_pkg::ST_DONE;
          ppur_pkg::OP_NONE: state_nxt = ppur_pkg::ST_DONE;
        endcase
      end
      ppur_pkg::ST_EMIT_MUL: state_nxt = ppur_pkg::ST_EMIT_WR;
      ppur_pkg::ST_EMIT_WR:  state_nxt = ppur_pkg::ST_DONE;
      ppur_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = ppur_pkg::ST_IDLE;
      end
      ppur_pkg::ST_ADV_SCAN: begin
        if (sts.slot_act) state_nxt = ppur_pkg::ST_ADV_CHK;
        else if (sts.idx_end) state_nxt = ppur_pkg::ST_DONE;
      end
      ppur_pkg::ST_ADV_CHK:
        state_nxt = sts.life_dead ? ppur_pkg::ST_ADV_NEXT : ppur_pkg::ST_ADV_MOD;
      ppur_pkg::ST_ADV_MOD: begin
        if (mod_last) state_nxt = ppur_pkg::ST_ADV_WR;
      end
      ppur_pkg::ST_ADV_WR: state_nxt = ppur_pkg::ST_ADV_NEXT;
      ppur_pkg::ST_ADV_NEXT:
        state_nxt = sts.idx_end ? ppur_pkg::ST_DONE : ppur_pkg::ST_ADV_SCAN;
      ppur_pkg::ST_REN_SCAN: begin
        if (sts.slot_act) state_nxt = ppur_pkg::ST_REN_DIV0;
      end
      ppur_pkg::ST_REN_DIV0:
        state_nxt = sts.frac_direct ? ppur_pkg::ST_REN_MUL : ppur_pkg::ST_REN_DIV;
      ppur_pkg::ST_REN_DIV: begin
        if (div_last) state_nxt = ppur_pkg::ST_REN_MUL;
      end
      ppur_pkg::ST_REN_MUL: state_nxt = ppur_pkg::ST_REN_OUT;
      ppur_pkg::ST_REN_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.more_after ? ppur_pkg::ST_REN_SCAN : ppur_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppur_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if (state_r == ppur_pkg::ST_ADV_MOD || state_r == ppur_pkg::ST_REN_DIV) begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ppur_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ppur_pkg::ST_DISPATCH: begin
        cmd.ptr_step = (sts.op == ppur_pkg::OP_EMIT) && !sts.emit_free;
      end
      ppur_pkg::ST_EMIT_MUL: cmd.emit_mul = 1'b1;
      ppur_pkg::ST_EMIT_WR: begin
        cmd.emit_wr  = 1'b1;
        cmd.ptr_step = 1'b1;
      end
      ppur_pkg::ST_DONE: cmd.out_empty = sts.out_free;
      ppur_pkg::ST_ADV_SCAN: begin
        cmd.ram_rd  = sts.slot_act;
        cmd.idx_inc = !sts.slot_act && !sts.idx_end;
      end
      ppur_pkg::ST_ADV_CHK: begin
        cmd.retire  = sts.life_dead;
        cmd.adv_mul = !sts.life_dead;
      end
      ppur_pkg::ST_ADV_MOD:  cmd.mod_step = 1'b1;
      ppur_pkg::ST_ADV_WR:   cmd.adv_wr = 1'b1;
      ppur_pkg::ST_ADV_NEXT: cmd.idx_inc = !sts.idx_end;
      ppur_pkg::ST_REN_SCAN: begin
        cmd.ram_rd  = sts.slot_act;
        cmd.idx_inc = !sts.slot_act;
      end
      ppur_pkg::ST_REN_DIV0: cmd.div_init = 1'b1;
      ppur_pkg::ST_REN_DIV:  cmd.div_step = 1'b1;
      ppur_pkg::ST_REN_MUL:  cmd.rnd_mul = 1'b1;
      ppur_pkg::ST_REN_OUT: begin
        cmd.out_draw = sts.out_free;
        cmd.idx_inc  = sts.out_free && sts.more_after;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[sv/ppur_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool datapath
// Registers, slot memory, multipliers, divider and result register.
// ----------------------------------------------------------------------------
module ppur_dp #(
  parameter int POOL_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  ppur_pkg::in_word_t   in_data,
  input  ppur_pkg::ctl_cmd_t   cmd,
  output ppur_pkg::ctl_sts_t   sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ppur_pkg::out_word_t  out_data
);

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  logic [30:0]        vsx_r, vsy_r, life_r, sspr_r;
  logic [31:0]        scol_r, fcol_r;
  logic signed [31:0] ssize_r, esize_r;

  ppur_pkg::in_word_t req_r;
  logic [POOL_SIZE-1:0] active_r, active_nxt;
  logic [6:0]         alive_r, alive_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt, idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  ppur_pkg::out_word_t out_r, out_nxt;

  logic [34:0]        ang_p_r;
  logic signed [49:0] jx_r, jy_r, js_r;
  logic signed [31:0] life_new_r;
  logic signed [52:0] px_p_r, py_p_r;
  logic [ppur_pkg::SUM_W-1:0] ang_r, mod_r;
  logic [31:0]        rem_r;
  logic [16:0]        f_r;
  logic signed [50:0] size_p_r;
  logic signed [26:0] col_p_r [4];

  ppur_pkg::slot_t    rd, wr_word, new_slot, adv_slot;
  logic               ram_we;
  logic [IDX_W-1:0]   waddr;

  logic signed [17:0] rjx, rjy, rjs, f_s;
  logic signed [20:0] dt_s;
  logic [32:0]        div_t;
  logic               div_ge, left_le0, total_le0, more_after;
  logic signed [32:0] sdiff;
  logic [31:0]        col_mix;

  ppur_ram #(
    .WIDTH ($bits(ppur_pkg::slot_t)),
    .DEPTH (POOL_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_word),
    .re    (cmd.ram_rd),
    .raddr (idx_r),
    .rdata (rd)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsx_r   <= 31'd65536;
      vsy_r   <= 31'd65536;
      scol_r  <= 32'hFFFF_FFFF;
      fcol_r  <= 32'h0000_0000;
      life_r  <= 31'd65536;
      ssize_r <= 32'sd32768;
      sspr_r  <= 31'd19661;
      esize_r <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (ppur_pkg::cfg_reg_t'(cfg_index))
        ppur_pkg::REG_VEL_SPREAD_X: vsx_r   <= cfg_data[30:0];
        ppur_pkg::REG_VEL_SPREAD_Y: vsy_r   <= cfg_data[30:0];
        ppur_pkg::REG_START_COLOR:  scol_r  <= cfg_data;
        ppur_pkg::REG_FINAL_COLOR:  fcol_r  <= cfg_data;
        ppur_pkg::REG_LIFE_SPAN:    life_r  <= cfg_data[30:0];
        ppur_pkg::REG_START_SIZE:   ssize_r <= cfg_data;
        ppur_pkg::REG_SIZE_SPREAD:  sspr_r  <= cfg_data[30:0];
        ppur_pkg::REG_END_SIZE:     esize_r <= cfg_data;
      endcase
    end
  end

  // Pool bookkeeping.
  always_comb begin
    active_nxt = active_r;
    alive_nxt  = alive_r;
    if (cmd.emit_wr) begin
      active_nxt[ptr_r] = 1'b1;
      alive_nxt         = alive_r + 7'd1;
    end
    if (cmd.retire) begin
      active_nxt[idx_r] = 1'b0;
      alive_nxt         = alive_r - 7'd1;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_step) begin
      ptr_nxt = (ptr_r == '0) ? IDX_W'(POOL_SIZE - 1) : ptr_r - IDX_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.take) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  assign out_valid_nxt = (cmd.out_empty || cmd.out_draw) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      alive_r     <= '0;
      ptr_r       <= IDX_W'(POOL_SIZE - 1);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      alive_r     <= alive_nxt;
      ptr_r       <= ptr_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Arithmetic operands.
  assign rjx  = $signed({2'b00, req_r.rand_jitter_x}) - 18'(ppur_pkg::HALF_Q16);
  assign rjy  = $signed({2'b00, req_r.rand_jitter_y}) - 18'(ppur_pkg::HALF_Q16);
  assign rjs  = $signed({2'b00, req_r.rand_size}) - 18'(ppur_pkg::HALF_Q16);
  assign dt_s = $signed({1'b0, req_r.time_step});
  assign f_s  = $signed({1'b0, f_r});

  assign div_t  = {rem_r, 1'b0};
  assign div_ge = div_t >= {1'b0, rd.life_total};
  assign sdiff  = 33'(rd.size_begin) - 33'(rd.size_end);

  assign left_le0  = rd.life_left[31] || (rd.life_left == '0);
  assign total_le0 = rd.life_total[31] || (rd.life_total == '0);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= in_data;
    end
    if (cmd.emit_mul) begin
      ang_p_r <= 35'(req_r.rand_angle) * 35'(ppur_pkg::TWO_PI_Q);
      jx_r    <= $signed({1'b0, vsx_r}) * rjx;
      jy_r    <= $signed({1'b0, vsy_r}) * rjy;
      js_r    <= $signed({1'b0, sspr_r}) * rjs;
    end
    if (cmd.adv_mul) begin
      life_new_r <= rd.life_left - $signed({12'b0, req_r.time_step});
      px_p_r     <= rd.vel_x * dt_s;
      py_p_r     <= rd.vel_y * dt_s;
      ang_r      <= ppur_pkg::SUM_W'(rd.angle)
                    + ppur_pkg::SUM_W'(req_r.time_step) * ppur_pkg::SUM_W'(ppur_pkg::SPIN_RATE);
      mod_r      <= ppur_pkg::SUM_W'(ppur_pkg::TWO_PI_Q) << (ppur_pkg::MOD_STEPS - 1);
    end
    if (cmd.mod_step) begin
      if (ang_r >= mod_r) begin
        ang_r <= ang_r - mod_r;
      end
      mod_r <= mod_r >> 1;
    end
    if (cmd.div_init) begin
      rem_r <= rd.life_left;
      f_r   <= (!left_le0 && !total_le0 && rd.life_left >= rd.life_total) ?
               17'(ppur_pkg::FRAC_ONE) : 17'd0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? 32'(div_t - {1'b0, rd.life_total}) : div_t[31:0];
      f_r   <= {f_r[15:0], div_ge};
    end
    if (cmd.rnd_mul) begin
      size_p_r <= sdiff * f_s;
      for (int c = 0; c < 4; c++) begin
        col_p_r[c] <= ($signed({1'b0, rd.color_begin[8*c +: 8]})
                      - $signed({1'b0, rd.color_end[8*c +: 8]})) * f_s;
      end
    end
    if (cmd.out_empty || cmd.out_draw) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.alive_total = alive_r;
    out_nxt.last        = 1'b1;
    if (cmd.out_draw) begin
      out_nxt.draw_valid = 1'b1;
      out_nxt.draw_x     = rd.pos_x;
      out_nxt.draw_y     = rd.pos_y;
      out_nxt.draw_angle = rd.angle;
      out_nxt.draw_size  = ppur_pkg::sat32(40'(rd.size_end) + 40'(size_p_r >>> 16));
      out_nxt.draw_color = col_mix;
      out_nxt.last       = !more_after;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      col_mix[8*c +: 8] = rd.color_end[8*c +: 8] + 8'(col_p_r[c] >>> 16);
    end
  end

  always_comb begin
    new_slot             = '0;
    new_slot.pos_x       = req_r.spawn_x;
    new_slot.pos_y       = req_r.spawn_y;
    new_slot.vel_x       = ppur_pkg::sat32(40'(req_r.base_vel_x) + 40'(jx_r >>> 16));
    new_slot.vel_y       = ppur_pkg::sat32(40'(req_r.base_vel_y) + 40'(jy_r >>> 16));
    new_slot.angle       = ang_p_r[34:16];
    new_slot.life_left   = $signed({1'b0, life_r});
    new_slot.life_total  = $signed({1'b0, life_r});
    new_slot.color_begin = scol_r;
    new_slot.color_end   = fcol_r;
    new_slot.size_begin  = ppur_pkg::sat32(40'(ssize_r) + 40'(js_r >>> 16));
    new_slot.size_end    = esize_r;

    adv_slot           = rd;
    adv_slot.pos_x     = ppur_pkg::sat32(40'(rd.pos_x) + 40'(px_p_r >>> 16));
    adv_slot.pos_y     = ppur_pkg::sat32(40'(rd.pos_y) + 40'(py_p_r >>> 16));
    adv_slot.angle     = ang_r[ppur_pkg::ANG_W-1:0];
    adv_slot.life_left = life_new_r;
  end

  assign ram_we  = cmd.emit_wr || cmd.adv_wr;
  assign waddr   = cmd.emit_wr ? ptr_r : idx_r;
  assign wr_word = cmd.emit_wr ? new_slot : adv_slot;

  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < POOL_SIZE; j++) begin
      if (active_r[j] && (j > int'(idx_r))) more_after = 1'b1;
    end
  end

  always_comb begin
    sts             = '0;
    sts.op          = ppur_pkg::op_t'(req_r.operation);
    sts.emit_free   = !active_r[ptr_r];
    sts.any_act     = |active_r;
    sts.slot_act    = active_r[idx_r];
    sts.idx_end     = (idx_r == IDX_W'(POOL_SIZE - 1));
    sts.more_after  = more_after;
    sts.life_dead   = left_le0;
    sts.frac_direct = left_le0 || total_le0 || (rd.life_left >= rd.life_total);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/particle_pool_update_render_core.sv]
`timescale 1ns / 1ps
// Emit fills the slot at the pointer unless that slot is taken; advance retires expired slots
// and moves the others, with a six-step angle modulo; render draws each active slot, with a
// 16-step divide for its life fraction where needed; any output stall holds the result.
// One item is processed at a time; the next is taken once its last result is registered.
// Synchronous active-low reset clears the active flags, count, pointer and registers.
// ----------------------------------------------------------------------------
// Particle pool update and render core
// Ring pool of particles with emit, advance and render operations.
// ----------------------------------------------------------------------------
module particle_pool_update_render_core #(
  parameter int POOL_SIZE = 64
) (
  input logic       clk,
  input logic       rst_n,
  ppur_in_if.sink   in_ch,
  ppur_out_if.source out_ch,
  ppur_cfg_if.sink  cfg_ch
);

  ppur_pkg::ctl_cmd_t cmd;
  ppur_pkg::ctl_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  ppur_ctrl u_ppur_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppur_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ppur_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule

[sv/ppur_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppur_checker #(
  parameter int POOL_SIZE = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ppur_pkg::out_word_t out_data
);

  `PPUR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result word valid after reset")
  `PPUR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
  `PPUR_ASSERT(a_empty_last, out_valid && !out_data.draw_valid |-> out_data.last, "empty word not last")
  `PPUR_ASSERT(a_empty_zero, out_valid && !out_data.draw_valid |-> out_data.draw_x == 0 && out_data.draw_y == 0 && out_data.draw_angle == 0 && out_data.draw_size == 0 && out_data.draw_color == 0, "empty word has data")
  `PPUR_ASSERT(a_ranges, out_valid |-> out_data.draw_angle < 19'(ppur_pkg::TWO_PI_Q) && out_data.alive_total <= 7'(POOL_SIZE), "field out of range")

endmodule

bind particle_pool_update_render_core ppur_checker #(
  .POOL_SIZE (POOL_SIZE)
) u_ppur_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[tb/sv/ppur_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool checker
// Watches the register, input and result channels. It keeps its own copy of
// the pool and the registers, works out the result words each accepted input
// word causes, and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module ppur_tb_checker (
  input  logic clk,
  input  logic rst_n,
  ppur_in_if   in_ch,
  ppur_out_if  out_ch,
  ppur_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int SLOTS = 64;

  logic [30:0] spread_x, spread_y, span, size_spread;
  logic [31:0] color_start, color_final, size_start, size_final;
  ppur_pkg::slot_t     pool [SLOTS];
  logic                active [SLOTS];
  logic [5:0]          emit_ptr;
  logic [6:0]          alive;
  ppur_pkg::out_word_t draws_due [$];

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint jitter_of(input logic [30:0] spread, input logic [15:0] r);
    return (longint'(spread) * (longint'(r) - ppur_pkg::HALF_Q16)) >>> 16;
  endfunction

  task automatic predict(input ppur_pkg::in_word_t w);
    ppur_pkg::out_word_t o;
    longint    dt, f, b, e, left, total;
    int        n;
    o = '0;
    n = 0;
    dt = longint'(w.time_step);
    case (ppur_pkg::op_t'(w.operation))
      ppur_pkg::OP_EMIT: begin
        if (!active[emit_ptr]) begin
          active[emit_ptr] = 1'b1;
          alive = alive + 7'd1;
          pool[emit_ptr].pos_x = w.spawn_x;
          pool[emit_ptr].pos_y = w.spawn_y;
          pool[emit_ptr].angle = 19'((longint'(w.rand_angle) * ppur_pkg::TWO_PI_Q) >>> 16);
          pool[emit_ptr].vel_x = clamp32(longint'(w.base_vel_x) +
                                         jitter_of(spread_x, w.rand_jitter_x));
          pool[emit_ptr].vel_y = clamp32(longint'(w.base_vel_y) +
                                         jitter_of(spread_y, w.rand_jitter_y));
          pool[emit_ptr].color_begin = color_start;
          pool[emit_ptr].color_end = color_final;
          pool[emit_ptr].life_total = {1'b0, span};
          pool[emit_ptr].life_left = {1'b0, span};
          pool[emit_ptr].size_begin = clamp32(longint'($signed(size_start)) +
                                              jitter_of(size_spread, w.rand_size));
          pool[emit_ptr].size_end = size_final;
        end
        emit_ptr = emit_ptr - 6'd1;
      end
      ppur_pkg::OP_ADVANCE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!active[i]) continue;
          if (pool[i].life_left <= 0) begin
            active[i] = 1'b0;
            alive = alive - 7'd1;
            continue;
          end
          pool[i].life_left = clamp32(longint'(pool[i].life_left) - dt);
          pool[i].pos_x = clamp32(longint'(pool[i].pos_x) +
                                  ((longint'(pool[i].vel_x) * dt) >>> 16));
          pool[i].pos_y = clamp32(longint'(pool[i].pos_y) +
                                  ((longint'(pool[i].vel_y) * dt) >>> 16));
          pool[i].angle = 19'((longint'(pool[i].angle) + ppur_pkg::SPIN_RATE * dt)
                              % ppur_pkg::TWO_PI_Q);
        end
      end
      ppur_pkg::OP_RENDER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!active[i]) continue;
          left = longint'(pool[i].life_left);
          total = longint'(pool[i].life_total);
          if (left <= 0 || total <= 0) f = 0;
          else if (left >= total) f = ppur_pkg::FRAC_ONE;
          else f = (left * ppur_pkg::FRAC_ONE) / total;
          o = '0;
          o.draw_valid = 1'b1;
          o.draw_x = pool[i].pos_x;
          o.draw_y = pool[i].pos_y;
          o.draw_angle = pool[i].angle;
          b = longint'(pool[i].size_begin);
          e = longint'(pool[i].size_end);
          o.draw_size = clamp32(e + (((b - e) * f) >>> 16));
          for (int c = 0; c < 4; c++) begin
            b = longint'(pool[i].color_begin[8*c +: 8]);
            e = longint'(pool[i].color_end[8*c +: 8]);
            o.draw_color[8*c +: 8] = 8'(e + (((b - e) * f) >>> 16));
          end
          o.alive_total = alive;
          draws_due.push_back(o);
          n++;
        end
        if (n > 0) draws_due[draws_due.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
    if (n == 0) begin
      o = '0;
      o.alive_total = alive;
      o.last = 1'b1;
      draws_due.push_back(o);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ppur_pkg::out_word_t x;
    if (!rst_n) begin
      spread_x = 31'd65536;
      spread_y = 31'd65536;
      color_start = 32'hFFFF_FFFF;
      color_final = 32'd0;
      span = 31'd65536;
      size_start = 32'd32768;
      size_spread = 31'd19661;
      size_final = 32'd0;
      for (int i = 0; i < SLOTS; i++) active[i] = 1'b0;
      emit_ptr = 6'd63;
      alive = 7'd0;
      fail_count = 0;
      draws_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (ppur_pkg::cfg_reg_t'(cfg_ch.index))
          ppur_pkg::REG_VEL_SPREAD_X: spread_x = cfg_ch.data[30:0];
          ppur_pkg::REG_VEL_SPREAD_Y: spread_y = cfg_ch.data[30:0];
          ppur_pkg::REG_START_COLOR:  color_start = cfg_ch.data;
          ppur_pkg::REG_FINAL_COLOR:  color_final = cfg_ch.data;
          ppur_pkg::REG_LIFE_SPAN:    span = cfg_ch.data[30:0];
          ppur_pkg::REG_START_SIZE:   size_start = cfg_ch.data;
          ppur_pkg::REG_SIZE_SPREAD:  size_spread = cfg_ch.data[30:0];
          ppur_pkg::REG_END_SIZE:     size_final = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (draws_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          x = draws_due.pop_front();
          check_field("draw_valid", 32'(x.draw_valid), 32'(out_ch.data.draw_valid));
          check_field("draw_x", x.draw_x, out_ch.data.draw_x);
          check_field("draw_y", x.draw_y, out_ch.data.draw_y);
          check_field("draw_angle", 32'(x.draw_angle), 32'(out_ch.data.draw_angle));
          check_field("draw_size", x.draw_size, out_ch.data.draw_size);
          check_field("draw_color", x.draw_color, out_ch.data.draw_color);
          check_field("alive_total", 32'(x.alive_total), 32'(out_ch.data.alive_total));
          check_field("last", 32'(x.last), 32'(out_ch.data.last));
        end
      end
    end
    pending = draws_due.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool testbench
// Drives a directed opening and then random emit, advance, render and no-op
// words over several register settings, with bursty input, a stalling
// receiver and one long receiver hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   burst_left;
  int   idle_cycles;
  bit   hold_req;

  ppur_in_if  in_ch ();
  ppur_out_if out_ch ();
  ppur_cfg_if cfg_ch ();

  particle_pool_update_render_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ppur_tb_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int seg_len;
    bit seg_stall;
    out_ch.ready <= 1'b0;
    seg_len = 0;
    seg_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_len == 0) begin
          seg_len = $urandom_range(20, 80);
          seg_stall = ($urandom_range(0, 1) != 0);
        end
        seg_len--;
        out_ch.ready <= seg_stall ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  function automatic ppur_pkg::in_word_t rand_word(input ppur_pkg::op_t op);
    ppur_pkg::in_word_t w;
    w.operation = op;
    w.spawn_x = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << 22);
    w.spawn_y = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 1 << 22);
    w.base_vel_x = ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 1 << 20) - (1 << 19);
    w.base_vel_y = ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 1 << 20) - (1 << 19);
    w.rand_angle = 16'($urandom);
    w.rand_jitter_x = 16'($urandom);
    w.rand_jitter_y = 16'($urandom);
    w.rand_size = 16'($urandom);
    w.time_step = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                              : 20'($urandom_range(0, 8192));
    return w;
  endfunction

  function automatic ppur_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) return ppur_pkg::OP_EMIT;
    if (r < 80) return ppur_pkg::OP_ADVANCE;
    if (r < 96) return ppur_pkg::OP_RENDER;
    return ppur_pkg::OP_NONE;
  endfunction

  task automatic push_item(input ppur_pkg::in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= ppur_pkg::cfg_reg_t'(i);
      cfg_ch.data <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    ppur_pkg::in_word_t w;
    logic [31:0]        vals [8];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= ppur_pkg::REG_VEL_SPREAD_X;
    cfg_ch.data <= '0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    w = rand_word(ppur_pkg::OP_EMIT);
    w.spawn_x = 32'sh7FFF_FFFF;
    w.spawn_y = 32'sh7FFF_FFFF;
    w.base_vel_x = 32'sh7FFF_FFFF;
    w.base_vel_y = 32'sh7FFF_FFFF;
    w.rand_angle = 16'hFFFF;
    w.rand_jitter_x = 16'hFFFF;
    w.rand_jitter_y = 16'hFFFF;
    w.rand_size = 16'hFFFF;
    push_item(w);
    w.spawn_x = 32'sh8000_0000;
    w.spawn_y = 32'sh8000_0000;
    w.base_vel_x = 32'sh8000_0000;
    w.base_vel_y = 32'sh8000_0000;
    w.rand_angle = 16'h0000;
    w.rand_jitter_x = 16'h0000;
    w.rand_jitter_y = 16'h0000;
    w.rand_size = 16'h0000;
    push_item(w);
    push_item(rand_word(ppur_pkg::OP_RENDER));
    w = rand_word(ppur_pkg::OP_ADVANCE);
    w.time_step = 20'd0;
    push_item(w);
    w.time_step = 20'hFFFFF;
    push_item(w);
    push_item(rand_word(ppur_pkg::OP_RENDER));
    push_item(rand_word(ppur_pkg::OP_ADVANCE));
    push_item(rand_word(ppur_pkg::OP_RENDER));
    push_item(rand_word(ppur_pkg::OP_NONE));
    push_item(rand_word(ppur_pkg::OP_EMIT));
    push_item(rand_word(ppur_pkg::OP_EMIT));
    w = rand_word(ppur_pkg::OP_ADVANCE);
    w.time_step = 20'd16384;
    push_item(w);
    push_item(rand_word(ppur_pkg::OP_RENDER));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        1: vals = '{32'h0, 32'h0, $urandom, $urandom,
                    32'h1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF};
        default: vals = '{$urandom, $urandom, $urandom, $urandom,
                          $urandom_range(1, 200000), $urandom, $urandom, $urandom};
      endcase
      write_regs(vals);
      for (int k = 0; k < 90; k++) begin
        if (ph == 2 && k == 40) hold_req = 1'b1;
        push_item(rand_word(pick_op()));
      end
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[particle_pool_update_render_core.f]
+incdir+sv
sv/ppur_pkg.sv
sv/ppur_intf.sv
sv/ppur_ram.sv
sv/ppur_ctrl.sv
sv/ppur_dp.sv
sv/particle_pool_update_render_core.sv
sv/ppur_checker.sv
tb/sv/ppur_checker.sv
tb/sv/tb.sv
